@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/pcsc_pkg.sv @@
package pcsc_pkg;

    localparam int WORD_W = 32;
    localparam int CRC_W  = 32;
    localparam int SUM_W  = 32;
    localparam int BYTE_W = 8;
    localparam int CFG_W  = 32;

    localparam logic [CRC_W-1:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_ZERO     = '0;

    // configuration register indexes
    localparam logic CFG_EXPECTED_CRC = 1'b0;
    localparam logic CFG_EXPECTED_SUM = 1'b1;

    typedef logic [CRC_W-1:0] crc_t;
    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [WORD_W-1:0][CRC_W-1:0] crc_cols_t;

    // Column i: contribution of bit i of (crc ^ word) after 32 reflected shifts.
    function automatic crc_cols_t build_crc_cols();
        crc_cols_t cols;
        crc_t      c;
        for (int i = 0; i < WORD_W; i++) begin
            c = crc_t'(1) << i;
            for (int s = 0; s < WORD_W; s++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            cols[i] = c;
        end
        return cols;
    endfunction

    localparam crc_cols_t CRC_COLS = build_crc_cols();

    // CRC register after four bytes, LSB first; linear, so one XOR network.
    function automatic crc_t crc32_word(crc_t crc, word_t word);
        crc_t  res;
        word_t v;
        res = '0;
        v   = crc ^ word;
        for (int i = 0; i < WORD_W; i++) begin
            if (v[i]) begin
                res = res ^ CRC_COLS[i];
            end
        end
        return res;
    endfunction

    function automatic sum_t byte_sum4(sum_t acc, word_t word);
        sum_t s;
        s = acc;
        for (int k = 0; k < WORD_W / BYTE_W; k++) begin
            s = s + sum_t'(word[k*BYTE_W +: BYTE_W]);
        end
        return s;
    endfunction

endpackage

@@ hdl/pcsc_if.sv @@
interface pcsc_in_if import pcsc_pkg::*; ();
    logic        valid;
    logic        ready;
    word_t       payload_word;
    logic        last_word;

    modport source (output valid, output payload_word, output last_word, input ready);
    modport sink   (input valid, input payload_word, input last_word, output ready);
endinterface

interface pcsc_out_if import pcsc_pkg::*; ();
    logic        valid;
    logic        ready;
    crc_t        crc_value;
    sum_t        sum_value;
    logic        crc_ok;
    logic        sum_ok;

    modport source (output valid, output crc_value, output sum_value,
                    output crc_ok, output sum_ok, input ready);
    modport sink   (input valid, input crc_value, input sum_value,
                    input crc_ok, input sum_ok, output ready);
endinterface

@@ hdl/payload_crc32_and_byte_sum_check_top.sv @@
// Payload CRC-32 and byte-sum checker. Takes one 32-bit payload word per
// transfer on in_ch (last_word marks the end of a payload) and folds its four
// bytes, least significant first, into a zlib-style reflected CRC-32 and a
// wrapping 32-bit byte sum. On the last word one result transfer on out_ch
// carries the final CRC (inverted), the sum, and crc_ok / sum_ok against the
// expected_crc (index 0) and expected_sum (index 1) registers; the running
// state then returns to its reset values. Sustained rate is one word per
// clock: the whole 32-bit CRC step is a single XOR network and the sum is one
// four-byte adder, both between the input register and the state/result
// registers. out_ch.valid is driven by the result register, which loads as
// the last word leaves the input register. in_ch.ready drops only while a
// finished result waits on out_ch and the next last word is already queued
// behind it.
`include "assert_macros.svh"

module payload_crc32_and_byte_sum_check_top
    import pcsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    pcsc_in_if.sink          in_ch,
    pcsc_out_if.source       out_ch
);

    // configuration
    crc_t expected_crc_reg;
    sum_t expected_sum_reg;

    // input register
    logic  s1_vld_reg;
    word_t s1_word_reg;
    logic  s1_last_reg;

    // running state
    crc_t crc_reg, crc_next;
    sum_t sum_reg, sum_next;

    // result register
    logic out_vld_reg, out_vld_next;
    crc_t crc_value_reg;
    sum_t sum_value_reg;
    logic crc_ok_reg;
    logic sum_ok_reg;

    logic s1_adv;
    logic in_ready;
    logic in_xfer;
    crc_t crc_final;

    // last word leaving stage 1 into the result register
    logic res_load;
    // last word sitting in stage 1
    logic last_held;
    // running state at its reset values
    logic state_idle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_crc_reg <= '0;
            expected_sum_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_EXPECTED_CRC: expected_crc_reg <= crc_t'(cfg_data);
                CFG_EXPECTED_SUM: expected_sum_reg <= sum_t'(cfg_data);
                default: ;
            endcase
        end
    end

    // Stage 1 moves on unless it holds a last word and the result slot is
    // still occupied and not being taken (out_ch.ready low).
    assign s1_adv   = s1_vld_reg && (!s1_last_reg || !out_vld_reg || out_ch.ready);
    assign in_ready = !s1_vld_reg || s1_adv;
    assign in_xfer  = in_ch.valid && in_ready;
    assign in_ch.ready = in_ready;

    assign res_load   = s1_adv && s1_last_reg;
    assign last_held  = s1_vld_reg && s1_last_reg;
    assign state_idle = (crc_reg == CRC_ALL_ONES) && (sum_reg == SUM_ZERO);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_vld_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_word_reg <= in_ch.payload_word;
            s1_last_reg <= in_ch.last_word;
        end
    end

    // Combinational word update of both checks.
    always_comb
    begin
        crc_next  = crc32_word(crc_reg, s1_word_reg);
        sum_next  = byte_sum4(sum_reg, s1_word_reg);
        crc_final = crc_next ^ CRC_ALL_ONES;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_ALL_ONES;
            sum_reg <= SUM_ZERO;
        end
        else if (s1_adv)
        begin
            // end of payload restarts the running state
            crc_reg <= s1_last_reg ? CRC_ALL_ONES : crc_next;
            sum_reg <= s1_last_reg ? SUM_ZERO : sum_next;
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg && !out_ch.ready;
        if (res_load)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            crc_value_reg <= crc_final;
            sum_value_reg <= sum_next;
            crc_ok_reg    <= (crc_final == expected_crc_reg);
            sum_ok_reg    <= (sum_next == expected_sum_reg);
        end
    end

    assign out_ch.valid     = out_vld_reg;
    assign out_ch.crc_value = crc_value_reg;
    assign out_ch.sum_value = sum_value_reg;
    assign out_ch.crc_ok    = crc_ok_reg;
    assign out_ch.sum_ok    = sum_ok_reg;

    // a new result never lands on one that is still waiting
    `ASSERT_CLK(a_no_overwrite, res_load |-> (!out_vld_reg || out_ch.ready), "result overwritten")
    // state is back at reset values right after a payload ends
    `ASSERT_CLK(a_state_restart, res_load |=> state_idle, "running state not cleared")
    // a result appears only after a last word left stage 1
    `ASSERT_CLK(a_result_source, $rose(out_vld_reg) |-> $past(res_load), "result without last word")
    // input stalls only behind a blocked result
    `ASSERT_CLK(a_stall_cause, !in_ready |-> (last_held && out_vld_reg && !out_ch.ready), "input stalled")

endmodule
